// ----- hdl/tam_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tam_pkg
// Shared widths, register codes, sequencer states and the arctangent table
// of the tilt angle monitor.
// ----------------------------------------------------------------------------
package tam_pkg;

  localparam int unsigned AccW   = 17;
  localparam int unsigned SqW    = 33;
  localparam int unsigned RadW   = 58;
  localparam int unsigned RootW  = 30;
  localparam int unsigned CW     = 18;
  localparam int unsigned XyW    = 32;
  localparam int unsigned ZW     = 25;
  localparam int unsigned AngW   = 15;
  localparam int unsigned Steps  = 20;
  localparam logic [15:0] AngleMax = 16'd23040;
  localparam logic [ZW-1:0] Base90 = 25'd5898240;

  localparam logic [2:0] REG_FULL_SCALE = 3'd0;
  localparam logic [2:0] REG_LASER_AXIS = 3'd1;
  localparam logic [2:0] REG_MAG_MIN    = 3'd2;
  localparam logic [2:0] REG_MAG_MAX    = 3'd3;
  localparam logic [2:0] REG_MAX_ANGLE  = 3'd4;
  localparam logic [2:0] REG_HYST       = 3'd5;
  localparam logic [2:0] REG_FAULT_DEB  = 3'd6;
  localparam logic [2:0] REG_RECOV_DEB  = 3'd7;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQR  = 6'b000010,
    ST_MAG  = 6'b000100,
    ST_PSQ  = 6'b001000,
    ST_ROT  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  function automatic logic [21:0] atan_deg16(input logic [4:0] idx);
    logic [21:0] r;
    unique case (idx)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tam_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tam_sqrt
// Digit-by-digit square root, one result bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module tam_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tam_pkg::RadW-1:0]    rad_i,
  output logic                             done_o,
  output logic [tam_pkg::RootW-1:0]        root_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [4:0]                  cnt_q;
  logic [tam_pkg::RadW-1:0]    rad_q;
  logic [31:0]                 rem_q;
  logic [28:0]                 res_q;
  logic [tam_pkg::RootW-1:0]   root_q;
  logic [31:0]                 rem_sh;
  logic [31:0]                 trial;
  logic                        ge;
  logic [31:0]                 rem_n;
  logic [28:0]                 res_n;

  always_comb begin
    rem_sh = {rem_q[29:0], rad_q[tam_pkg::RadW-1 -: 2]};
    trial  = {1'b0, res_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_n  = ge ? rem_sh - trial : rem_sh;
    res_n  = {res_q[27:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd28;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q <= rad_i;
      rem_q <= 32'd0;
      res_q <= 29'd0;
    end else if (busy_q) begin
      rad_q <= {rad_q[tam_pkg::RadW-3:0], 2'b00};
      rem_q <= rem_n;
      res_q <= res_n;
      if (cnt_q == 5'd0) begin
        root_q <= {1'b0, res_n} + {29'd0, (rem_n > {3'd0, res_n})};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ----- hdl/tam_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tam_cordic
// Vectoring CORDIC for the angle from down, one rotation step per cycle.
// ----------------------------------------------------------------------------
module tam_cordic (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [tam_pkg::CW-1:0]     c_i,
  input  wire logic [tam_pkg::RootW-1:0]         p_i,
  output logic                                   done_o,
  output logic [tam_pkg::AngW-1:0]               angle_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [4:0]                         idx_q;
  logic signed [tam_pkg::XyW-1:0]     x_q;
  logic signed [tam_pkg::XyW-1:0]     y_q;
  logic signed [tam_pkg::ZW-1:0]      z_q;
  logic [tam_pkg::AngW-1:0]           angle_q;
  logic signed [tam_pkg::XyW-1:0]     c_ext;
  logic signed [tam_pkg::XyW-1:0]     dx;
  logic signed [tam_pkg::XyW-1:0]     dy;
  logic signed [tam_pkg::ZW-1:0]      at;
  logic signed [tam_pkg::ZW-1:0]      z_n;
  logic [tam_pkg::ZW-1:0]             z_pos;
  logic [tam_pkg::ZW-1:0]             rsum;
  logic [15:0]                        code;

  always_comb begin
    c_ext = {{(tam_pkg::XyW-tam_pkg::CW){c_i[tam_pkg::CW-1]}}, c_i};
    dx    = y_q >>> idx_q;
    dy    = x_q >>> idx_q;
    at    = $signed({3'b000, tam_pkg::atan_deg16(idx_q)});
    z_n   = (y_q > 0) ? z_q + at : z_q - at;
    z_pos = z_n[tam_pkg::ZW-1] ? '0 : z_n;
    rsum  = z_pos + 25'd256;
    code  = rsum[24:9];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= 5'd0;
      end else if (busy_q) begin
        idx_q <= idx_q + 5'd1;
        if (idx_q == 5'(tam_pkg::Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (!c_i[tam_pkg::CW-1]) begin
        x_q <= c_ext <<< 12;
        y_q <= $signed({2'b00, p_i});
        z_q <= '0;
      end else begin
        x_q <= $signed({2'b00, p_i});
        y_q <= (-c_ext) <<< 12;
        z_q <= tam_pkg::Base90;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
      end
      z_q <= z_n;
      if (idx_q == 5'(tam_pkg::Steps - 1)) begin
        angle_q <= (code > tam_pkg::AngleMax) ? tam_pkg::AngleMax[14:0] : code[14:0];
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule
`default_nettype wire

// ----- hdl/tilt_angle_monitor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_angle_monitor
// Accelerometer tilt monitor with magnitude window and debounced ok flag.
// ----------------------------------------------------------------------------
// One sample is handled at a time. A good sample passes from acceptance to
// result through squaring on the shared multiplier, two passes of the shared
// square root unit (magnitude, then the off-axis component), the CORDIC unit
// and the load of the output register. A sample outside the window skips the
// second root and the CORDIC, and a failed read goes straight to the output
// register. The input is ready again once the result has moved into the
// output register, so a stalled output holds the input off.
module tilt_angle_monitor (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] raw_x_i,
  input  wire logic signed [15:0] raw_y_i,
  input  wire logic signed [15:0] raw_z_i,
  input  wire logic               read_failed_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [16:0]      accel_x_o,
  output logic signed [16:0]      accel_y_o,
  output logic signed [16:0]      accel_z_o,
  output logic [16:0]             magnitude_o,
  output logic                    sample_valid_o,
  output logic [14:0]             down_angle_o,
  output logic                    tilt_ok_o
);

  logic [1:0]  full_scale_q;
  logic [2:0]  laser_axis_q;
  logic [16:0] mag_min_q, mag_max_q;
  logic [14:0] max_angle_q, hyst_q;
  logic [7:0]  fault_deb_q, recov_deb_q;
  logic        wr_en;

  tam_pkg::state_e state_q, state_d;
  logic signed [tam_pkg::AccW-1:0] a_q [3];
  logic [1:0]  k_q;
  logic [tam_pkg::SqW-1:0] sq0_q, sq1_q, sq2_q;
  logic [16:0] mag_q;
  logic        valid_q;
  logic [14:0] angle_q;
  logic        zero_q;
  logic        ok_q;
  logic [7:0]  fcnt_q, rcnt_q;

  logic signed [33:0] prod;
  logic [33:0] mag_sum, uv_sum;
  logic [2:0]  sel;
  logic signed [tam_pkg::CW-1:0] c_val;
  logic        sq_start;
  logic [tam_pkg::RadW-1:0] rad;
  logic        sq_done;
  logic [tam_pkg::RootW-1:0] root;
  logic        co_start, co_done;
  logic [14:0] co_angle;
  logic        win_ok;
  logic [14:0] ang_fin;
  logic        over, back;
  logic signed [15:0] recover_at;
  logic [7:0]  fcnt_inc, rcnt_inc;
  logic        accept_in, load_out;

  function automatic logic signed [16:0] scale(input logic [1:0] fs,
                                               input logic signed [15:0] r);
    logic signed [16:0] e;
    logic signed [16:0] s;
    e = {r[15], r};
    unique case (fs)
      2'd0: s = e >>> 2;
      2'd1: s = e >>> 1;
      2'd2: s = e;
      default: s = e <<< 1;
    endcase
    return s;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= 2'd0;
      laser_axis_q <= 3'd0;
      mag_min_q    <= 17'd2048;
      mag_max_q    <= 17'd6144;
      max_angle_q  <= 15'd7680;
      hyst_q       <= 15'd640;
      fault_deb_q  <= 8'd1;
      recov_deb_q  <= 8'd3;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        tam_pkg::REG_FULL_SCALE: full_scale_q <= pwdata[1:0];
        tam_pkg::REG_LASER_AXIS: laser_axis_q <= pwdata[2:0];
        tam_pkg::REG_MAG_MIN:    mag_min_q    <= pwdata[16:0];
        tam_pkg::REG_MAG_MAX:    mag_max_q    <= pwdata[16:0];
        tam_pkg::REG_MAX_ANGLE:  max_angle_q  <= pwdata[14:0];
        tam_pkg::REG_HYST:       hyst_q       <= pwdata[14:0];
        tam_pkg::REG_FAULT_DEB:  fault_deb_q  <= pwdata[7:0];
        default:                 recov_deb_q  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tam_pkg::REG_FULL_SCALE: prdata = {30'd0, full_scale_q};
      tam_pkg::REG_LASER_AXIS: prdata = {29'd0, laser_axis_q};
      tam_pkg::REG_MAG_MIN:    prdata = {15'd0, mag_min_q};
      tam_pkg::REG_MAG_MAX:    prdata = {15'd0, mag_max_q};
      tam_pkg::REG_MAX_ANGLE:  prdata = {17'd0, max_angle_q};
      tam_pkg::REG_HYST:       prdata = {17'd0, hyst_q};
      tam_pkg::REG_FAULT_DEB:  prdata = {24'd0, fault_deb_q};
      default:                 prdata = {24'd0, recov_deb_q};
    endcase
  end

  assign in_ready_o = (state_q == tam_pkg::ST_IDLE);
  assign accept_in  = in_valid_i && in_ready_o;
  assign load_out   = (state_q == tam_pkg::ST_DONE) && (!out_valid_o || out_ready_i);

  always_comb begin
    prod    = a_q[k_q] * a_q[k_q];
    mag_sum = {1'b0, sq0_q} + {1'b0, sq1_q} + {1'b0, sq2_q};
    sel     = (laser_axis_q > 3'd5) ? 3'd0 : laser_axis_q;
    unique case (sel[2:1])
      2'd0: begin
        c_val  = {a_q[0][16], a_q[0]};
        uv_sum = {1'b0, sq1_q} + {1'b0, sq2_q};
      end
      2'd1: begin
        c_val  = {a_q[1][16], a_q[1]};
        uv_sum = {1'b0, sq2_q} + {1'b0, sq0_q};
      end
      default: begin
        c_val  = {a_q[2][16], a_q[2]};
        uv_sum = {1'b0, sq0_q} + {1'b0, sq1_q};
      end
    endcase
    if (!sel[0]) begin
      c_val = -c_val;
    end
    win_ok   = (root[16:0] >= mag_min_q) && (root[16:0] <= mag_max_q)
               && (root[29:17] == '0);
    sq_start = 1'b0;
    rad      = {24'd0, mag_sum};
    if ((state_q == tam_pkg::ST_SQR) && (k_q == 2'd3)) begin
      sq_start = 1'b1;
    end else if ((state_q == tam_pkg::ST_MAG) && sq_done && win_ok) begin
      sq_start = 1'b1;
      rad      = {uv_sum, 24'd0};
    end
    co_start = (state_q == tam_pkg::ST_PSQ) && sq_done;
  end

  tam_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (rad),
    .done_o  (sq_done),
    .root_o  (root)
  );

  tam_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (co_start),
    .c_i     (c_val),
    .p_i     (root),
    .done_o  (co_done),
    .angle_o (co_angle)
  );

  always_comb begin
    ang_fin    = zero_q ? 15'd0 : co_angle;
    recover_at = $signed({1'b0, max_angle_q}) - $signed({1'b0, hyst_q});
    over       = ang_fin >= max_angle_q;
    back       = $signed({1'b0, ang_fin}) <= recover_at;
    fcnt_inc   = (fcnt_q == 8'hFF) ? fcnt_q : fcnt_q + 8'd1;
    rcnt_inc   = (rcnt_q == 8'hFF) ? rcnt_q : rcnt_q + 8'd1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tam_pkg::ST_IDLE: if (accept_in) begin
        state_d = read_failed_i ? tam_pkg::ST_DONE : tam_pkg::ST_SQR;
      end
      tam_pkg::ST_SQR: if (k_q == 2'd3) begin
        state_d = tam_pkg::ST_MAG;
      end
      tam_pkg::ST_MAG: if (sq_done) begin
        state_d = win_ok ? tam_pkg::ST_PSQ : tam_pkg::ST_DONE;
      end
      tam_pkg::ST_PSQ: if (sq_done) begin
        state_d = tam_pkg::ST_ROT;
      end
      tam_pkg::ST_ROT: if (co_done) begin
        state_d = tam_pkg::ST_DONE;
      end
      default: if (load_out) begin
        state_d = tam_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tam_pkg::ST_IDLE;
      k_q         <= 2'd0;
      ok_q        <= 1'b0;
      fcnt_q      <= 8'd0;
      rcnt_q      <= 8'd0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept_in) begin
        k_q <= 2'd0;
        if (read_failed_i) begin
          ok_q <= 1'b0;
        end
      end else if (state_q == tam_pkg::ST_SQR) begin
        k_q <= k_q + 2'd1;
      end
      if ((state_q == tam_pkg::ST_MAG) && sq_done && !win_ok) begin
        ok_q <= 1'b0;
      end
      if ((state_q == tam_pkg::ST_ROT) && co_done) begin
        if (ok_q) begin
          rcnt_q <= 8'd0;
          if (over) begin
            fcnt_q <= fcnt_inc;
            if (fcnt_inc >= fault_deb_q) begin
              ok_q <= 1'b0;
            end
          end else begin
            fcnt_q <= 8'd0;
          end
        end else begin
          fcnt_q <= 8'd0;
          if (back) begin
            rcnt_q <= rcnt_inc;
            if (rcnt_inc >= recov_deb_q) begin
              ok_q <= 1'b1;
            end
          end else begin
            rcnt_q <= 8'd0;
          end
        end
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      valid_q <= 1'b0;
      angle_q <= 15'd0;
      mag_q   <= 17'd0;
      if (read_failed_i) begin
        a_q[0] <= '0;
        a_q[1] <= '0;
        a_q[2] <= '0;
      end else begin
        a_q[0] <= scale(full_scale_q, raw_x_i);
        a_q[1] <= scale(full_scale_q, raw_y_i);
        a_q[2] <= scale(full_scale_q, raw_z_i);
      end
    end
    if ((state_q == tam_pkg::ST_SQR) && (k_q != 2'd3)) begin
      unique case (k_q)
        2'd0:    sq0_q <= prod[32:0];
        2'd1:    sq1_q <= prod[32:0];
        default: sq2_q <= prod[32:0];
      endcase
    end
    if ((state_q == tam_pkg::ST_MAG) && sq_done) begin
      mag_q   <= root[16:0];
      valid_q <= win_ok;
      zero_q  <= (c_val == '0) && (uv_sum == '0);
    end
    if ((state_q == tam_pkg::ST_ROT) && co_done) begin
      angle_q <= ang_fin;
    end
    if (load_out) begin
      accel_x_o      <= a_q[0];
      accel_y_o      <= a_q[1];
      accel_z_o      <= a_q[2];
      magnitude_o    <= mag_q;
      sample_valid_o <= valid_q;
      down_angle_o   <= angle_q;
      tilt_ok_o      <= ok_q;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> !in_ready_o)
    else $error("input ready right after a word was accepted");
  a_invalid_angle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_valid_o) |-> (down_angle_o == 15'd0))
    else $error("angle reported for an invalid sample");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, down_angle_o} <= tam_pkg::AngleMax))
    else $error("angle beyond 180 degrees");
  a_ok_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tilt_ok_o) |-> sample_valid_o)
    else $error("ok flag set on an invalid sample");
`endif

endmodule
`default_nettype wire
